FILE: rtl/dlts_pkg.sv
// Shared types and constants for the delta-list task scheduler.
// No dependencies.
package dlts_pkg;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_ADD      = 2'd1,
        REQ_DISPATCH = 2'd2,
        REQ_DELETE   = 2'd3
    } req_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_CLR_SUM,
        OP_WALK,
        OP_SHIFT_UP,
        OP_PLACE,
        OP_FIX_NEXT,
        OP_DEL_PREP,
        OP_SHIFT_DOWN,
        OP_DEL_LAST,
        OP_DISP_HEAD,
        OP_RUNQ_POP
    } op_t;

    // controller -> datapath
    typedef struct packed {
        op_t  op;
        logic use_carried_add;  // add issued by a dispatch re-insert
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic walk_done;
        logic walk_found;
        logic shift_done;
        logic del_bad;
        logic head_due;
        logic head_periodic;
    } dp_stat_t;

endpackage

FILE: rtl/dlts_datapath.sv
// Datapath of the delta-list scheduler: timer table, run FIFO, walk and shift unit.
// Depends on dlts_pkg.
module dlts_datapath import dlts_pkg::*; #(
    parameter int MAX_ENTRIES = 16,
    parameter int RUNQ_DEPTH  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [7:0] in_handle,
    input  logic [31:0] in_delay,
    input  logic [31:0] in_period,
    input  logic [3:0] in_index,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic [4:0] slot,
    output logic [7:0] pop_handle,
    output logic [7:0] pop_id,
    output logic       pop_valid
);

    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int QW = (RUNQ_DEPTH > 1) ? $clog2(RUNQ_DEPTH) : 1;
    localparam int QC = $clog2(RUNQ_DEPTH + 1);

    logic [7:0]  e_handle_reg [MAX_ENTRIES];
    logic [31:0] e_delta_reg  [MAX_ENTRIES];
    logic [31:0] e_period_reg [MAX_ENTRIES];
    logic [31:0] e_runs_reg   [MAX_ENTRIES];
    logic [7:0]  e_id_reg     [MAX_ENTRIES];
    logic [CW-1:0] count_reg;
    logic [7:0]  q_handle_reg [RUNQ_DEPTH];
    logic [7:0]  q_id_reg     [RUNQ_DEPTH];
    logic [QC-1:0] q_count_reg;
    logic [31:0] carried_runs_reg;
    logic [7:0]  carried_id_reg;

    // operation operands
    logic [7:0]  op_handle_reg;
    logic [31:0] op_delay_reg;
    logic [31:0] op_period_reg;
    logic [CW-1:0] ptr_reg;     // walk position / shift cursor
    logic [CW-1:0] pos_reg;     // target position
    logic [32:0] sum_reg;
    logic [32:0] before_reg;
    logic        found_reg;

    logic [EW-1:0] ptr_i, pos_i, pos1_i, ptrm1_i, ptrp1_i, last_i;
    logic [32:0]   sum_add;
    logic [32:0]   del_sum;

    assign ptr_i   = ptr_reg[EW-1:0];
    assign pos_i   = pos_reg[EW-1:0];
    assign pos1_i  = EW'(pos_reg + CW'(1));
    assign ptrm1_i = EW'(ptr_reg - CW'(1));
    assign ptrp1_i = EW'(ptr_reg + CW'(1));
    assign last_i  = EW'(count_reg - CW'(1));
    assign sum_add = sum_reg + {1'b0, e_delta_reg[ptr_i]};
    assign del_sum = {1'b0, e_delta_reg[pos1_i]} + {1'b0, e_delta_reg[pos_i]};

    assign stat.full       = (count_reg >= CW'(MAX_ENTRIES));
    assign stat.walk_done  = (ptr_reg >= count_reg) || (sum_add > {1'b0, op_delay_reg});
    assign stat.walk_found = found_reg;
    assign stat.shift_done = (cmd.op == OP_SHIFT_DOWN) ? (ptr_reg + CW'(1) >= count_reg)
                                                       : (ptr_reg <= pos_reg);
    assign stat.del_bad    = (pos_reg >= count_reg);
    assign stat.head_due   = (count_reg != '0) && (e_delta_reg[0] == '0)
                             && (e_runs_reg[0] != '0);
    assign stat.head_periodic = (e_period_reg[0] != '0);

    // a refused add reports the table size as its slot
    assign slot       = (cmd.op == OP_CLR_SUM) ? 5'(MAX_ENTRIES) : 5'(pos_reg);
    assign pop_valid  = (q_count_reg != '0);
    assign pop_handle = q_handle_reg[0];
    assign pop_id     = q_id_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            q_count_reg      <= '0;
            carried_runs_reg <= '0;
            carried_id_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_PLACE:
                begin
                    count_reg        <= count_reg + CW'(1);
                    carried_runs_reg <= '0;
                    carried_id_reg   <= '0;
                end
                OP_DEL_PREP:
                    if (pos_reg < count_reg && e_period_reg[pos_i] != '0)
                        carried_id_reg <= e_id_reg[pos_i];
                OP_DEL_LAST:
                    count_reg <= count_reg - CW'(1);
                OP_DISP_HEAD:
                begin
                    if (q_count_reg < QC'(RUNQ_DEPTH))
                        q_count_reg <= q_count_reg + QC'(1);
                    if (e_period_reg[0] != '0)
                        carried_runs_reg <= e_runs_reg[0] - 32'd1;
                end
                OP_RUNQ_POP:
                    if (q_count_reg != '0)
                        q_count_reg <= q_count_reg - QC'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_handle_reg <= in_handle;
            op_delay_reg  <= in_delay;
            op_period_reg <= in_period;
            pos_reg       <= CW'(in_index);
        end
        case (cmd.op)
            OP_TICK:
                if (count_reg != '0)
                begin
                    if (e_delta_reg[0] > 32'd1)
                        e_delta_reg[0] <= e_delta_reg[0] - 32'd1;
                    else
                    begin
                        e_delta_reg[0] <= '0;
                        if (e_runs_reg[0] != '1)
                            e_runs_reg[0] <= e_runs_reg[0] + 32'd1;
                    end
                end
            OP_CLR_SUM:
            begin
                sum_reg    <= '0;
                before_reg <= '0;
                found_reg  <= 1'b0;
                ptr_reg    <= '0;
            end
            OP_WALK:
                if (ptr_reg >= count_reg)
                begin
                    before_reg <= sum_reg;
                    pos_reg    <= ptr_reg;
                    ptr_reg    <= count_reg;
                end
                else if (sum_add > {1'b0, op_delay_reg})
                begin
                    before_reg <= sum_reg;
                    found_reg  <= 1'b1;
                    pos_reg    <= ptr_reg;
                    ptr_reg    <= count_reg;
                end
                else
                begin
                    sum_reg <= sum_add;
                    ptr_reg <= ptr_reg + CW'(1);
                end
            OP_SHIFT_UP:
                if (ptr_reg > pos_reg)
                begin
                    e_handle_reg[ptr_i] <= e_handle_reg[ptrm1_i];
                    e_delta_reg[ptr_i]  <= e_delta_reg[ptrm1_i];
                    e_period_reg[ptr_i] <= e_period_reg[ptrm1_i];
                    e_runs_reg[ptr_i]   <= e_runs_reg[ptrm1_i];
                    e_id_reg[ptr_i]     <= e_id_reg[ptrm1_i];
                    ptr_reg <= ptr_reg - CW'(1);
                end
            OP_PLACE:
            begin
                e_handle_reg[pos_i] <= op_handle_reg;
                e_delta_reg[pos_i]  <= 32'({1'b0, op_delay_reg} - before_reg);
                e_period_reg[pos_i] <= op_period_reg;
                e_runs_reg[pos_i]   <= carried_runs_reg;
                e_id_reg[pos_i]     <= (carried_id_reg != '0) ? carried_id_reg
                                       : 8'(count_reg + CW'(1));
            end
            OP_FIX_NEXT:
                // only an insert ahead of a later entry has a follower to fix
                if (found_reg)
                    e_delta_reg[pos1_i] <= e_delta_reg[pos1_i] - e_delta_reg[pos_i];
            OP_DEL_PREP:
            begin
                if (pos_reg + CW'(1) < count_reg)
                    e_delta_reg[pos1_i] <= del_sum[32] ? '1 : del_sum[31:0];
                ptr_reg <= pos_reg;
            end
            OP_SHIFT_DOWN:
                if (ptr_reg + CW'(1) < count_reg)
                begin
                    e_handle_reg[ptr_i] <= e_handle_reg[ptrp1_i];
                    e_delta_reg[ptr_i]  <= e_delta_reg[ptrp1_i];
                    e_period_reg[ptr_i] <= e_period_reg[ptrp1_i];
                    e_runs_reg[ptr_i]   <= e_runs_reg[ptrp1_i];
                    e_id_reg[ptr_i]     <= e_id_reg[ptrp1_i];
                    ptr_reg <= ptr_reg + CW'(1);
                end
            OP_DEL_LAST:
            begin
                e_handle_reg[last_i] <= '0;
                e_delta_reg[last_i]  <= '0;
                e_period_reg[last_i] <= '0;
                e_runs_reg[last_i]   <= '0;
                e_id_reg[last_i]     <= '0;
            end
            OP_DISP_HEAD:
            begin
                if (q_count_reg < QC'(RUNQ_DEPTH))
                begin
                    q_handle_reg[QW'(q_count_reg)] <= e_handle_reg[0];
                    q_id_reg[QW'(q_count_reg)]     <= e_id_reg[0];
                end
                e_runs_reg[0]  <= e_runs_reg[0] - 32'd1;
                op_handle_reg  <= e_handle_reg[0];
                op_delay_reg   <= e_period_reg[0];
                op_period_reg  <= e_period_reg[0];
                pos_reg        <= '0;
            end
            OP_RUNQ_POP:
                // FIFO is small; shift all entries at once, each a fixed tap
                for (int i = 0; i < RUNQ_DEPTH; i++)
                begin
                    if (i + 1 < RUNQ_DEPTH)
                    begin
                        q_handle_reg[i] <= q_handle_reg[(i + 1) % RUNQ_DEPTH];
                        q_id_reg[i]     <= q_id_reg[(i + 1) % RUNQ_DEPTH];
                    end
                end
            default: ;
        endcase
    end

endmodule

FILE: rtl/dlts_ctrl.sv
// Sequencer of the delta-list scheduler: steps the datapath through each request.
// Depends on dlts_pkg.
module dlts_ctrl import dlts_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] in_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       load,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat,
    input  logic [4:0] slot,
    input  logic       pop_valid,
    input  logic [7:0] pop_handle,
    input  logic [7:0] pop_id,
    output logic [1:0] status,
    output logic [4:0] slot_taken,
    output logic       run_valid,
    output logic [7:0] run_handle,
    output logic [7:0] run_id
);

    typedef enum logic [3:0] {
        S_IDLE, S_TICK, S_ADD_CLR, S_WALK, S_SHIFT_UP, S_PLACE, S_FIX,
        S_DEL_PREP, S_SHIFT_DN, S_DEL_LAST, S_DISP, S_DISP_HEAD, S_POP, S_DONE
    } state_t;

    state_t     state_reg;
    req_t       req_reg;
    logic       reins_reg;
    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic [4:0] slot_reg;
    logic       run_valid_reg;
    logic [7:0] run_handle_reg;
    logic [7:0] run_id_reg;

    assign in_stall   = (state_reg != S_IDLE) || out_valid_reg;
    assign load       = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_taken = slot_reg;
    assign run_valid  = run_valid_reg;
    assign run_handle = run_handle_reg;
    assign run_id     = run_id_reg;

    always_comb
    begin
        cmd.use_carried_add = reins_reg;
        case (state_reg)
            S_TICK:      cmd.op = OP_TICK;
            S_ADD_CLR:   cmd.op = OP_CLR_SUM;
            S_WALK:      cmd.op = OP_WALK;
            S_SHIFT_UP:  cmd.op = OP_SHIFT_UP;
            S_PLACE:     cmd.op = OP_PLACE;
            S_FIX:       cmd.op = OP_FIX_NEXT;
            S_DEL_PREP:  cmd.op = OP_DEL_PREP;
            S_SHIFT_DN:  cmd.op = OP_SHIFT_DOWN;
            S_DEL_LAST:  cmd.op = OP_DEL_LAST;
            S_DISP_HEAD: cmd.op = OP_DISP_HEAD;
            S_POP:       cmd.op = OP_RUNQ_POP;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= REQ_TICK;
            reins_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            slot_reg      <= '0;
            run_valid_reg <= 1'b0;
            run_handle_reg <= '0;
            run_id_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (load)
                    begin
                        req_reg       <= req_t'(in_req);
                        reins_reg     <= 1'b0;
                        status_reg    <= ST_OK;
                        slot_reg      <= '0;
                        run_valid_reg <= 1'b0;
                        run_handle_reg <= '0;
                        run_id_reg    <= '0;
                        case (req_t'(in_req))
                            REQ_TICK:   state_reg <= S_TICK;
                            REQ_ADD:    state_reg <= S_ADD_CLR;
                            REQ_DELETE: state_reg <= S_DEL_PREP;
                            default:    state_reg <= S_DISP;
                        endcase
                    end
                S_TICK:
                    state_reg <= S_DONE;
                S_ADD_CLR:
                    if (stat.full)
                    begin
                        if (!reins_reg)
                        begin
                            status_reg <= ST_FULL;
                            slot_reg   <= slot;
                        end
                        state_reg <= reins_reg ? S_POP : S_DONE;
                    end
                    else
                        state_reg <= S_WALK;
                S_WALK:
                    if (stat.walk_done)
                        state_reg <= S_SHIFT_UP;
                S_SHIFT_UP:
                    if (stat.shift_done)
                        state_reg <= S_PLACE;
                S_PLACE:
                    state_reg <= S_FIX;
                S_FIX:
                begin
                    if (!reins_reg)
                        slot_reg <= slot;
                    state_reg <= reins_reg ? S_POP : S_DONE;
                end
                S_DEL_PREP:
                    if (req_reg == REQ_DELETE && stat.del_bad)
                    begin
                        status_reg <= ST_EMPTY;
                        state_reg  <= S_DONE;
                    end
                    else
                        state_reg <= S_SHIFT_DN;
                S_SHIFT_DN:
                    if (stat.shift_done)
                        state_reg <= S_DEL_LAST;
                S_DEL_LAST:
                    if (reins_reg)
                        state_reg <= S_ADD_CLR;
                    else if (req_reg == REQ_DELETE)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_POP;
                S_DISP:
                    state_reg <= stat.head_due ? S_DISP_HEAD : S_POP;
                S_DISP_HEAD:
                begin
                    reins_reg <= stat.head_periodic;
                    state_reg <= S_DEL_PREP;
                end
                S_POP:
                begin
                    run_valid_reg  <= pop_valid;
                    run_handle_reg <= pop_valid ? pop_handle : 8'd0;
                    run_id_reg     <= pop_valid ? pop_id : 8'd0;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/delta_list_task_scheduler.sv
// Delta-list timer queue with a cooperative run FIFO. One request at a time. An add walks the
// table and then shifts entries up; a delete shifts entries down; a dispatch that re-inserts a
// periodic task deletes the head and then adds it back. The walk and shift loops step one entry
// per cycle. A finished result waits in the output register and holds off the next request.
// Top level; depends on dlts_pkg, dlts_ctrl, dlts_datapath.
module delta_list_task_scheduler import dlts_pkg::*; #(
    parameter int MAX_ENTRIES = 16,
    parameter int RUNQ_DEPTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  task_handle,
    input  logic [31:0] first_delay,
    input  logic [31:0] repeat_period,
    input  logic [3:0]  entry_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [4:0]  slot_taken,
    output logic        run_valid,
    output logic [7:0]  run_handle,
    output logic [7:0]  run_id
);

    logic       load;
    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [4:0] slot;
    logic       pop_valid;
    logic [7:0] pop_handle;
    logic [7:0] pop_id;

    dlts_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .in_req(req_type), .out_valid, .out_stall,
        .load, .cmd, .stat, .slot, .pop_valid, .pop_handle, .pop_id,
        .status, .slot_taken, .run_valid, .run_handle, .run_id
    );

    dlts_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .RUNQ_DEPTH(RUNQ_DEPTH)) u_dp (
        .clk, .rst_n, .load, .in_handle(task_handle), .in_delay(first_delay),
        .in_period(repeat_period), .in_index(entry_index), .cmd, .stat, .slot,
        .pop_handle, .pop_id, .pop_valid
    );

endmodule

FILE: rtl/dlts_checker.sv
// Port-level checks for the delta-list scheduler, bound to the top level.
// Depends on dlts_pkg.
module dlts_checker import dlts_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic       run_valid,
    input logic [7:0] run_handle,
    input logic [7:0] run_id
);

    // one request in flight: no new transaction while a result waits
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled result changed");

    a_idle_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_valid |-> run_handle == 8'd0 && run_id == 8'd0)
        else $error("run fields nonzero without run");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_valid |-> status == ST_OK)
        else $error("dispatch with error status");

endmodule

bind delta_list_task_scheduler dlts_checker u_dlts_checker (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .status, .run_valid, .run_handle, .run_id
);

FILE: sim/delta_list_task_scheduler_test.sv
// Self-checking testbench for delta_list_task_scheduler: directed and random requests,
// checked against an in-bench model of the delta-list table and run FIFO.
// Depends on dlts_pkg and the scheduler RTL.
module delta_list_task_scheduler_test import dlts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT = 16;
    localparam int NRUNQ = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = 2'd0;
    logic [7:0]  task_handle = 8'd0;
    logic [31:0] first_delay = 32'd0;
    logic [31:0] repeat_period = 32'd0;
    logic [3:0]  entry_index = 4'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [4:0]  slot_taken;
    logic        run_valid;
    logic [7:0]  run_handle;
    logic [7:0]  run_id;

    delta_list_task_scheduler dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] slot;
        logic       rv;
        logic [7:0] rh;
        logic [7:0] rid;
    } sched_result_t;

    // model state
    logic [7:0]  m_handle [NENT];
    logic [31:0] m_delta [NENT];
    logic [31:0] m_period [NENT];
    logic [31:0] m_runs [NENT];
    logic [7:0]  m_id [NENT];
    int          m_count;
    logic [7:0]  q_handle [NRUNQ];
    logic [7:0]  q_id [NRUNQ];
    int          q_count;
    logic [31:0] carry_runs;
    logic [7:0]  carry_id;

    sched_result_t expected_results[$];
    int mismatches = 0;
    int idle_pct = 19;
    bit hold_rx = 0;
    int quiet_cycles = 0;

    function automatic void move_slot(int d, int s);
        m_handle[d] = m_handle[s];
        m_delta[d] = m_delta[s];
        m_period[d] = m_period[s];
        m_runs[d] = m_runs[s];
        m_id[d] = m_id[s];
    endfunction

    function automatic int insert_task(logic [7:0] h, logic [31:0] dly, logic [31:0] per);
        logic [63:0] sum;
        logic [63:0] prior;
        bit found;
        int p;
        sum = 0;
        prior = 0;
        found = 0;
        if (m_count >= NENT)
            return NENT;
        for (p = 0; p < m_count; p++)
        begin
            prior = sum;
            sum += m_delta[p];
            if (sum > {32'd0, dly})
            begin
                found = 1;
                break;
            end
        end
        if (!found)
            prior = sum;
        for (int i = m_count; i > p; i--)
            move_slot(i, i - 1);
        m_count++;
        m_handle[p] = h;
        m_delta[p] = 32'({32'd0, dly} - prior);
        m_period[p] = per;
        m_runs[p] = carry_runs;
        m_id[p] = (carry_id != 0) ? carry_id : 8'(m_count);
        if (found)
            m_delta[p + 1] -= m_delta[p];
        carry_runs = 0;
        carry_id = 0;
        return p;
    endfunction

    function automatic bit remove_task(int idx);
        logic [32:0] s;
        if (idx >= m_count)
            return 0;
        if (m_period[idx] > 0)
            carry_id = m_id[idx];
        if (idx + 1 < m_count)
        begin
            s = {1'b0, m_delta[idx + 1]} + {1'b0, m_delta[idx]};
            m_delta[idx + 1] = s[32] ? 32'hFFFF_FFFF : s[31:0];
        end
        for (int i = idx; i + 1 < m_count; i++)
            move_slot(i, i + 1);
        m_handle[m_count - 1] = 0;
        m_delta[m_count - 1] = 0;
        m_period[m_count - 1] = 0;
        m_runs[m_count - 1] = 0;
        m_id[m_count - 1] = 0;
        m_count--;
        return 1;
    endfunction

    function automatic sched_result_t schedule_step(req_t rq, logic [7:0] h, logic [31:0] dly,
                                                    logic [31:0] per, logic [3:0] idx);
        sched_result_t r;
        logic [7:0] hh;
        logic [31:0] pp;
        int dummy;
        r = '0;
        case (rq)
            REQ_TICK:
                if (m_count > 0)
                begin
                    if (m_delta[0] > 0)
                        m_delta[0]--;
                    if (m_delta[0] == 0 && m_runs[0] != 32'hFFFF_FFFF)
                        m_runs[0]++;
                end
            REQ_ADD:
            begin
                dummy = insert_task(h, dly, per);
                r.slot = 5'(dummy);
                if (dummy == NENT)
                    r.status = ST_FULL;
            end
            REQ_DELETE:
                if (!remove_task(idx))
                    r.status = ST_EMPTY;
            default:
            begin
                if (m_count > 0 && m_delta[0] == 0 && m_runs[0] > 0)
                begin
                    if (q_count < NRUNQ)
                    begin
                        q_handle[q_count] = m_handle[0];
                        q_id[q_count] = m_id[0];
                        q_count++;
                    end
                    m_runs[0]--;
                    if (m_period[0] > 0)
                    begin
                        hh = m_handle[0];
                        pp = m_period[0];
                        carry_runs = m_runs[0];
                        void'(remove_task(0));
                        void'(insert_task(hh, pp, pp));
                    end
                    else
                        void'(remove_task(0));
                end
                if (q_count > 0)
                begin
                    r.rv = 1;
                    r.rh = q_handle[0];
                    r.rid = q_id[0];
                    for (int i = 0; i + 1 < q_count; i++)
                    begin
                        q_handle[i] = q_handle[i + 1];
                        q_id[i] = q_id[i + 1];
                    end
                    q_handle[q_count - 1] = 0;
                    q_id[q_count - 1] = 0;
                    q_count--;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_request(req_t rq, logic [7:0] h = 8'd0, logic [31:0] dly = 32'd0,
                                logic [31:0] per = 32'd0, logic [3:0] idx = 4'd0);
        // valid was dropped at the previous falling edge; wait for a later falling edge before raising it
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        in_valid <= 1'b1;
        req_type <= rq;
        task_handle <= h;
        first_delay <= dly;
        repeat_period <= per;
        entry_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(schedule_step(rq, h, dly, per, idx));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // receiver stall
    always @(negedge clk)
        out_stall <= hold_rx || ($urandom_range(99) < idle_pct);

    // result checker
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            sched_result_t got, want;
            got = {status, slot_taken, run_valid, run_handle, run_id};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d slot %0d/%0d run %0d/%0d h %0d/%0d id %0d/%0d",
                                 want.status, got.status, want.slot, got.slot, want.rv, got.rv,
                                 want.rh, got.rh, want.rid, got.rid);
                end
            end
        end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("delta_list_task_scheduler regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rand_delay();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(8);
        endcase
    endfunction

    task automatic test_directed();
        send_request(REQ_TICK);
        send_request(REQ_DISPATCH);
        send_request(REQ_DELETE, 8'd0, 32'd0, 32'd0, 4'd15);
        send_request(REQ_ADD, 8'd0, 32'd0, 32'd0);
        send_request(REQ_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_ADD, 8'hA5, 32'd2, 32'd3);
        send_request(REQ_ADD, 8'h5A, 32'd2, 32'd0);
        send_request(REQ_TICK);
        send_request(REQ_DISPATCH);
        send_request(REQ_DISPATCH);
        send_request(REQ_TICK);
        send_request(REQ_TICK);
        send_request(REQ_DISPATCH);
        send_request(REQ_DISPATCH);
        send_request(REQ_DELETE, 8'd0, 32'd0, 32'd0, 4'd0);
        send_request(REQ_ADD, 8'h11, 32'd5, 32'd1);
        send_request(REQ_DELETE, 8'd0, 32'd0, 32'd0, 4'd1);
        for (int i = 0; i < 16; i++)
            send_request(REQ_ADD, 8'(i), 32'(i), 32'd1);
        send_request(REQ_ADD, 8'h77, 32'd1, 32'd1);
    endtask

    task automatic test_random(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            if (i > n / 2 && i < n / 2 + 150)
                idle_pct = 0;
            else
                idle_pct = 19;
            pick = $urandom_range(99);
            if (pick < 35)
                send_request(REQ_TICK);
            else if (pick < 60)
                send_request(REQ_ADD, 8'($urandom), rand_delay(),
                             ($urandom_range(2) == 0) ? 32'd0 :
                             ($urandom_range(9) == 0 ? $urandom : $urandom_range(1, 6)));
            else if (pick < 85)
                send_request(REQ_DISPATCH);
            else
                send_request(REQ_DELETE, 8'd0, 32'd0, 32'd0, 4'($urandom));
        end
        idle_pct = 19;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1;
                repeat (300) @(negedge clk);
                hold_rx = 0;
            end
            for (int i = 0; i < 20; i++)
                send_request(REQ_TICK);
        join
    endtask

    initial
    begin
        m_count = 0;
        q_count = 0;
        carry_runs = 0;
        carry_id = 0;
        for (int i = 0; i < NENT; i++)
        begin
            m_handle[i] = 0; m_delta[i] = 0; m_period[i] = 0; m_runs[i] = 0; m_id[i] = 0;
        end
        for (int i = 0; i < NRUNQ; i++)
        begin
            q_handle[i] = 0; q_id[i] = 0;
        end
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(600);
        test_backpressure();
        test_random(650);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("delta_list_task_scheduler regression: pass");
        else
            $display("delta_list_task_scheduler regression: fail");
        $finish;
    end
endmodule
